>>> rtl/weighted_icp_normal_equation_accumulator_macros.svh
// Assertion helpers used by the accumulator's controller.
`ifndef WEIGHTED_ICP_NORMAL_EQUATION_ACCUMULATOR_MACROS_SVH
`define WEIGHTED_ICP_NORMAL_EQUATION_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define WICP_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("wicp check failed");
`define WICP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wicp check failed");
`else
`define WICP_ASSERT(lbl, expr)
`define WICP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> rtl/wicp_pkg.sv
`timescale 1ns / 1ps
package wicp_pkg;

    localparam int IN_W      = 32;
    localparam int KER_W     = 32;
    localparam int ACC_W     = 64;
    localparam int CNT_OUT_W = 13;
    localparam int MUL_W     = 34;
    localparam int SPLIT_W   = 25;
    localparam int NUM_ACC   = 7;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_UX, S_UY, S_T1, S_T2, S_T2F, S_WAIT,
        S_RR, S_WCAP, S_PX, S_NPY, S_RX, S_RY, S_RADH, S_RADL, S_ROTH,
        S_ROTL, S_ROTF, S_ACCROT, S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_AXAX, MUL_AYAY, MUL_UXUX, MUL_UYUY, MUL_PXRY, MUL_PYRX,
        MUL_RR, MUL_WPX, MUL_WNPY, MUL_WRX, MUL_WRY, MUL_WRADH, MUL_WRADL,
        MUL_WROTH, MUL_WROTL
    } mul_op_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_SX, DST_RSQ, DST_RADLO, DST_RADHI, DST_T1, DST_T2,
        DST_W, DST_PART, DST_COMB
    } dst_t;

    typedef enum logic [2:0] {
        ACC_WSUM = 3'd0, ACC_PX = 3'd1, ACC_NPY = 3'd2, ACC_RAD = 3'd3,
        ACC_GX = 3'd4, ACC_GY = 3'd5, ACC_ROT = 3'd6, ACC_NONE = 3'd7
    } acc_sel_t;

    typedef enum logic [1:0] {
        SRC_WREG, SRC_PROD, SRC_COMB
    } acc_src_t;

    typedef struct packed {
        logic     load;
        mul_op_t  mul_op;
        dst_t     prod_dst;
        acc_sel_t acc_sel;
        acc_src_t acc_src;
        logic     div_start;
        logic     count;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic last;
    } status_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             sat;
    } sat_res_t;

    function automatic sat_res_t sat_add(input logic signed [ACC_W-1:0] a,
                                         input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        sat_res_t r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        r.sat = s[ACC_W] != s[ACC_W-1];
        if (!r.sat)
        begin
            r.sum = s[ACC_W-1:0];
        end
        else if (s[ACC_W])
        begin
            r.sum = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            r.sum = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/wicp_div.sv
`timescale 1ns / 1ps
module wicp_div
    import wicp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [KER_W+FRAC_BITS-1:0] dividend,
    input  logic [ACC_W-1:0]           divisor,
    output logic                       busy,
    output logic [FRAC_BITS:0]         quotient
);
    localparam int RM_W  = KER_W + FRAC_BITS;
    localparam int DS_W  = ACC_W + FRAC_BITS;
    localparam int STEPS = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [RM_W-1:0]    rem_reg, rem_next;
    logic [DS_W-1:0]    dsh_reg;
    logic [FRAC_BITS:0] quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, zero_reg;
    logic               ge;

    // quotient never exceeds 2^F, so only the low F+1 bits are developed
    assign ge       = DS_W'(rem_reg) >= dsh_reg;
    assign rem_next = rem_reg - dsh_reg[RM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= {divisor, {FRAC_BITS{1'b0}}};
            quo_reg  <= '0;
            zero_reg <= divisor == '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_next;
            end
            quo_reg <= {quo_reg[FRAC_BITS-1:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy     = busy_reg;
    assign quotient = zero_reg ? '0 : quo_reg;

endmodule

>>> rtl/wicp_dp.sv
`timescale 1ns / 1ps
module wicp_dp
    import wicp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_PAIRS = 4096
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    output status_t                     status,
    input  logic                        cfg_we,
    input  logic [KER_W-1:0]            cfg_data,
    input  logic signed [IN_W-1:0]      src_x,
    input  logic signed [IN_W-1:0]      src_y,
    input  logic signed [IN_W-1:0]      map_x,
    input  logic signed [IN_W-1:0]      map_y,
    input  logic                        last_pair,
    output logic signed [ACC_W-1:0]     weight_sum,
    output logic signed [ACC_W-1:0]     weighted_px_sum,
    output logic signed [ACC_W-1:0]     weighted_neg_py_sum,
    output logic signed [ACC_W-1:0]     weighted_radius_sum,
    output logic signed [ACC_W-1:0]     grad_x,
    output logic signed [ACC_W-1:0]     grad_y,
    output logic signed [ACC_W-1:0]     grad_rot,
    output logic [CNT_OUT_W-1:0]        pair_count,
    output logic                        overflow_flag
);
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int PROD_W = 2 * MUL_W;
    localparam int CMB_W  = PROD_W + SPLIT_W;

    logic [KER_W-1:0]             k_reg;
    logic signed [IN_W-1:0]       px_reg, py_reg;
    logic signed [IN_W:0]         rx_reg, ry_reg;
    logic                         last_reg;
    logic [ACC_W-1:0]             sx_reg, rsq_reg, rad_sum_reg;
    logic signed [ACC_W-1:0]      t1_reg, rot_reg;
    logic [FRAC_BITS:0]           w_reg;
    logic signed [PROD_W-1:0]     prod_reg, part_reg;
    logic signed [CMB_W-1:0]      comb_reg;
    logic signed [ACC_W-1:0]      acc_reg [NUM_ACC];
    logic [CNT_W-1:0]             cnt_reg;
    logic                         sat_reg;

    logic [IN_W:0]                ax, ay, ux, uy;
    logic signed [IN_W:0]         npy;
    logic [ACC_W-1:0]             rad;
    logic signed [MUL_W-1:0]      op_a, op_b;
    logic signed [PROD_W-1:0]     prod_shr;
    logic signed [CMB_W-1:0]      comb_shr, comb_next;
    logic signed [ACC_W-1:0]      term;
    logic [ACC_W:0]               rsq_sum;
    logic [FRAC_BITS:0]           ratio;
    logic                         div_busy;
    logic [ACC_W-1:0]             divisor;
    sat_res_t                     acc_res;
    logic [CNT_W+CNT_OUT_W-1:0]   cnt_ext;

    assign ax  = rx_reg[IN_W] ? (IN_W+1)'(1) + ~rx_reg : rx_reg;
    assign ay  = ry_reg[IN_W] ? (IN_W+1)'(1) + ~ry_reg : ry_reg;
    assign ux  = px_reg[IN_W-1] ? -{px_reg[IN_W-1], px_reg} : {1'b0, px_reg};
    assign uy  = py_reg[IN_W-1] ? -{py_reg[IN_W-1], py_reg} : {1'b0, py_reg};
    assign npy = -{py_reg[IN_W-1], py_reg};
    assign rad = rad_sum_reg >> FRAC_BITS;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_op)
            MUL_AXAX:  begin op_a = MUL_W'(ax); op_b = MUL_W'(ax); end
            MUL_AYAY:  begin op_a = MUL_W'(ay); op_b = MUL_W'(ay); end
            MUL_UXUX:  begin op_a = MUL_W'(ux); op_b = MUL_W'(ux); end
            MUL_UYUY:  begin op_a = MUL_W'(uy); op_b = MUL_W'(uy); end
            MUL_PXRY:  begin op_a = MUL_W'(px_reg); op_b = MUL_W'(ry_reg); end
            MUL_PYRX:  begin op_a = MUL_W'(py_reg); op_b = MUL_W'(rx_reg); end
            MUL_RR:    begin op_a = MUL_W'(ratio); op_b = MUL_W'(ratio); end
            MUL_WPX:   begin op_a = MUL_W'(w_reg); op_b = MUL_W'(px_reg); end
            MUL_WNPY:  begin op_a = MUL_W'(w_reg); op_b = MUL_W'(npy); end
            MUL_WRX:   begin op_a = MUL_W'(w_reg); op_b = MUL_W'(rx_reg); end
            MUL_WRY:   begin op_a = MUL_W'(w_reg); op_b = MUL_W'(ry_reg); end
            MUL_WRADH:
            begin
                op_a = MUL_W'(w_reg);
                op_b = rad[SPLIT_W+MUL_W-1:SPLIT_W];
            end
            MUL_WRADL:
            begin
                op_a = MUL_W'(w_reg);
                op_b = MUL_W'(rad[SPLIT_W-1:0]);
            end
            MUL_WROTH:
            begin
                op_a = MUL_W'(w_reg);
                op_b = rot_reg[SPLIT_W+MUL_W-1:SPLIT_W];
            end
            MUL_WROTL:
            begin
                op_a = MUL_W'(w_reg);
                op_b = {{(MUL_W-SPLIT_W){1'b0}}, rot_reg[SPLIT_W-1:0]};
            end
            default:   begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod_shr  = prod_reg >>> FRAC_BITS;
    assign comb_next = (CMB_W'(part_reg) <<< SPLIT_W) + CMB_W'(prod_reg);
    assign comb_shr  = comb_reg >>> FRAC_BITS;
    assign rsq_sum   = {1'b0, sx_reg} + {1'b0, prod_reg[ACC_W-1:0]};

    always_comb
    begin
        case (cmd.acc_src)
            SRC_WREG: term = ACC_W'(w_reg);
            SRC_PROD: term = prod_shr[ACC_W-1:0];
            SRC_COMB: term = comb_shr[ACC_W-1:0];
            default:  term = '0;
        endcase
    end

    assign acc_res = sat_add(acc_reg[cmd.acc_sel], term);

    assign divisor = ACC_W'(k_reg) + (rsq_reg >> FRAC_BITS);

    wicp_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({k_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (ratio)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= KER_W'(65536);
        end
        else if (cfg_we)
        begin
            k_reg <= cfg_data;
        end
    end

    // operand, intermediate and output registers
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (cmd.load)
        begin
            px_reg   <= src_x;
            py_reg   <= src_y;
            rx_reg   <= {src_x[IN_W-1], src_x} - {map_x[IN_W-1], map_x};
            ry_reg   <= {src_y[IN_W-1], src_y} - {map_y[IN_W-1], map_y};
            last_reg <= last_pair;
        end
        case (cmd.prod_dst)
            DST_SX:    sx_reg <= prod_reg[ACC_W-1:0];
            DST_RSQ:   rsq_reg <= rsq_sum[ACC_W] ? '1 : rsq_sum[ACC_W-1:0];
            DST_RADLO: rad_sum_reg <= prod_reg[ACC_W-1:0];
            DST_RADHI: rad_sum_reg <= rad_sum_reg + prod_reg[ACC_W-1:0];
            DST_T1:    t1_reg <= prod_shr[ACC_W-1:0];
            DST_T2:    rot_reg <= t1_reg - prod_shr[ACC_W-1:0];
            DST_W:     w_reg <= prod_reg[2*FRAC_BITS:FRAC_BITS];
            DST_PART:  part_reg <= prod_reg;
            DST_COMB:  comb_reg <= comb_next;
            default:   ;
        endcase
        if (cmd.emit)
        begin
            weight_sum          <= acc_reg[ACC_WSUM];
            weighted_px_sum     <= acc_reg[ACC_PX];
            weighted_neg_py_sum <= acc_reg[ACC_NPY];
            weighted_radius_sum <= acc_reg[ACC_RAD];
            grad_x              <= acc_reg[ACC_GX];
            grad_y              <= acc_reg[ACC_GY];
            grad_rot            <= acc_reg[ACC_ROT];
            pair_count          <= cnt_ext[CNT_OUT_W-1:0];
            overflow_flag       <= sat_reg;
        end
    end

    assign cnt_ext = (CNT_W + CNT_OUT_W)'(cnt_reg);

    // sums of the current set; clear once they are handed to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ACC; i++)
            begin
                acc_reg[i] <= '0;
            end
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < NUM_ACC; i++)
            begin
                acc_reg[i] <= '0;
            end
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_sel != ACC_NONE)
            begin
                acc_reg[cmd.acc_sel] <= acc_res.sum;
                if (acc_res.sat)
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (cmd.count && cnt_reg < CNT_W'(MAX_PAIRS))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign status.div_busy = div_busy;
    assign status.last     = last_reg;

endmodule

>>> rtl/wicp_ctrl.sv
`timescale 1ns / 1ps
`include "weighted_icp_normal_equation_accumulator_macros.svh"
module wicp_ctrl
    import wicp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '{load: 1'b0, mul_op: MUL_NONE, prod_dst: DST_NONE,
                           acc_sel: ACC_NONE, acc_src: SRC_PROD, div_start: 1'b0,
                           count: 1'b0, emit: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQX;
                end
            end
            S_SQX: begin cmd.mul_op = MUL_AXAX; state_next = S_SQY; end
            S_SQY:
            begin
                cmd.mul_op = MUL_AYAY; cmd.prod_dst = DST_SX; state_next = S_UX;
            end
            S_UX:
            begin
                cmd.mul_op = MUL_UXUX; cmd.prod_dst = DST_RSQ; state_next = S_UY;
            end
            S_UY:
            begin
                cmd.mul_op    = MUL_UYUY;
                cmd.prod_dst  = DST_RADLO;
                cmd.div_start = 1'b1;
                state_next    = S_T1;
            end
            S_T1:
            begin
                cmd.mul_op = MUL_PXRY; cmd.prod_dst = DST_RADHI; state_next = S_T2;
            end
            S_T2:
            begin
                cmd.mul_op = MUL_PYRX; cmd.prod_dst = DST_T1; state_next = S_T2F;
            end
            S_T2F: begin cmd.prod_dst = DST_T2; state_next = S_WAIT; end
            // hold until the weight ratio is out of the divider
            S_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_RR;
                end
            end
            S_RR:   begin cmd.mul_op = MUL_RR; state_next = S_WCAP; end
            S_WCAP: begin cmd.prod_dst = DST_W; state_next = S_PX; end
            S_PX:
            begin
                cmd.mul_op  = MUL_WPX;
                cmd.acc_sel = ACC_WSUM;
                cmd.acc_src = SRC_WREG;
                state_next  = S_NPY;
            end
            S_NPY:
            begin
                cmd.mul_op = MUL_WNPY; cmd.acc_sel = ACC_PX; state_next = S_RX;
            end
            S_RX:
            begin
                cmd.mul_op = MUL_WRX; cmd.acc_sel = ACC_NPY; state_next = S_RY;
            end
            S_RY:
            begin
                cmd.mul_op = MUL_WRY; cmd.acc_sel = ACC_GX; state_next = S_RADH;
            end
            S_RADH:
            begin
                cmd.mul_op = MUL_WRADH; cmd.acc_sel = ACC_GY; state_next = S_RADL;
            end
            S_RADL:
            begin
                cmd.mul_op = MUL_WRADL; cmd.prod_dst = DST_PART; state_next = S_ROTH;
            end
            S_ROTH:
            begin
                cmd.mul_op = MUL_WROTH; cmd.prod_dst = DST_COMB; state_next = S_ROTL;
            end
            S_ROTL:
            begin
                cmd.mul_op   = MUL_WROTL;
                cmd.prod_dst = DST_PART;
                cmd.acc_sel  = ACC_RAD;
                cmd.acc_src  = SRC_COMB;
                state_next   = S_ROTF;
            end
            S_ROTF: begin cmd.prod_dst = DST_COMB; state_next = S_ACCROT; end
            S_ACCROT:
            begin
                cmd.acc_sel = ACC_ROT;
                cmd.acc_src = SRC_COMB;
                cmd.count   = 1'b1;
                state_next  = status.last ? S_EMIT : S_IDLE;
            end
            // drop the sums into the output word once the old one is taken
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

    `WICP_ASSERT_IMPL(a_div_start_free, cmd.div_start, !status.div_busy)
    `WICP_ASSERT_IMPL(a_emit_on_last, cmd.emit, status.last)
    `WICP_ASSERT_IMPL(a_no_overwrite, cmd.emit, !out_valid_reg || out_ready)
    `WICP_ASSERT(a_weight_after_div, !(state_reg == S_RR && status.div_busy))

endmodule

>>> rtl/weighted_icp_normal_equation_accumulator.sv
`timescale 1ns / 1ps
// A last pair's result word is registered at emit, once its sequence has run;
// emit holds while the previous result word still waits.
// Pairs are taken one at a time, a new one only after the last has run the shared
// 34x34 multiplier sequence and the F+1 step radix-2 divider for the weight ratio.
// Reset: rst_n asynchronous, active low; clears sums, count, flag and handshakes,
// kernel scale returns to 65536 (1.0 at F=16).
module weighted_icp_normal_equation_accumulator
    import wicp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_PAIRS = 4096
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [KER_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  src_x,
    input  logic signed [IN_W-1:0]  src_y,
    input  logic signed [IN_W-1:0]  map_x,
    input  logic signed [IN_W-1:0]  map_y,
    input  logic                    last_pair,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ACC_W-1:0] weight_sum,
    output logic signed [ACC_W-1:0] weighted_px_sum,
    output logic signed [ACC_W-1:0] weighted_neg_py_sum,
    output logic signed [ACC_W-1:0] weighted_radius_sum,
    output logic signed [ACC_W-1:0] grad_x,
    output logic signed [ACC_W-1:0] grad_y,
    output logic signed [ACC_W-1:0] grad_rot,
    output logic [CNT_OUT_W-1:0]    pair_count,
    output logic                    overflow_flag
);
    cmd_t    cmd;
    status_t status;

    wicp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    wicp_dp #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .src_x               (src_x),
        .src_y               (src_y),
        .map_x               (map_x),
        .map_y               (map_y),
        .last_pair           (last_pair),
        .weight_sum          (weight_sum),
        .weighted_px_sum     (weighted_px_sum),
        .weighted_neg_py_sum (weighted_neg_py_sum),
        .weighted_radius_sum (weighted_radius_sum),
        .grad_x              (grad_x),
        .grad_y              (grad_y),
        .grad_rot            (grad_rot),
        .pair_count          (pair_count),
        .overflow_flag       (overflow_flag)
    );

endmodule

>>> bench/weighted_icp_normal_equation_accumulator_test.sv
`timescale 1ns / 1ps
module weighted_icp_normal_equation_accumulator_test;
    import wicp_pkg::*;

    localparam int FRAC = 16;
    localparam int PAIR_LIMIT = 4096;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_SET = 120;
    localparam longint CYCLE_LIMIT = 64'd1000000;
    localparam logic signed [IN_W-1:0] IN_MAX = 32'sh7FFFFFFF;
    localparam logic signed [IN_W-1:0] IN_MIN = 32'sh80000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [KER_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [IN_W-1:0] src_x;
    logic signed [IN_W-1:0] src_y;
    logic signed [IN_W-1:0] map_x;
    logic signed [IN_W-1:0] map_y;
    logic last_pair;
    logic out_valid;
    logic out_ready;
    logic signed [ACC_W-1:0] weight_sum;
    logic signed [ACC_W-1:0] weighted_px_sum;
    logic signed [ACC_W-1:0] weighted_neg_py_sum;
    logic signed [ACC_W-1:0] weighted_radius_sum;
    logic signed [ACC_W-1:0] grad_x;
    logic signed [ACC_W-1:0] grad_y;
    logic signed [ACC_W-1:0] grad_rot;
    logic [CNT_OUT_W-1:0] pair_count;
    logic overflow_flag;

    typedef struct {
        logic signed [ACC_W-1:0] sums[NUM_ACC];
        logic [CNT_OUT_W-1:0]    count;
        logic                    ovf;
    } normal_eq_t;

    normal_eq_t pending_sums[$];

    logic [KER_W-1:0]        model_kernel;
    logic signed [ACC_W-1:0] model_acc[NUM_ACC];
    logic [CNT_OUT_W-1:0]    model_count;
    logic                    model_ovf;

    int errors;
    int pairs_sent;
    int sets_checked;
    longint cycles;
    bit no_gaps;

    weighted_icp_normal_equation_accumulator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .src_x(src_x),
        .src_y(src_y),
        .map_x(map_x),
        .map_y(map_y),
        .last_pair(last_pair),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .weight_sum(weight_sum),
        .weighted_px_sum(weighted_px_sum),
        .weighted_neg_py_sum(weighted_neg_py_sum),
        .weighted_radius_sum(weighted_radius_sum),
        .grad_x(grad_x),
        .grad_y(grad_y),
        .grad_rot(grad_rot),
        .pair_count(pair_count),
        .overflow_flag(overflow_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [ACC_W-1:0] weighted(input logic [63:0] w,
                                                          input logic signed [127:0] v);
        logic signed [127:0] wv;
        logic signed [127:0] prod;
        wv = w;
        prod = wv * v;
        return prod >>> FRAC;
    endfunction

    task automatic clear_model_sums();
        for (int i = 0; i < NUM_ACC; i++)
        begin
            model_acc[i] = '0;
        end
        model_count = '0;
        model_ovf = 1'b0;
    endtask

    task automatic accumulate_pair(input logic signed [IN_W-1:0] sx32,
                                   input logic signed [IN_W-1:0] sy32,
                                   input logic signed [IN_W-1:0] mx32,
                                   input logic signed [IN_W-1:0] my32,
                                   input logic last);
        logic signed [127:0] px, py, rx, ry, ax, ay, ux, uy;
        logic [127:0] rsq_wide;
        logic [63:0] rsq, d, ratio, w;
        logic signed [127:0] rad, t1, t2;
        logic signed [ACC_W-1:0] terms[NUM_ACC];
        logic signed [ACC_W:0] s;
        normal_eq_t res;
        px = sx32;
        py = sy32;
        rx = px - mx32;
        ry = py - my32;
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        rsq_wide = ax * ax + ay * ay;
        rsq = rsq_wide > 128'hFFFF_FFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF_FFFF : rsq_wide[63:0];
        d = {32'd0, model_kernel} + (rsq >> FRAC);
        w = '0;
        if (d != 0)
        begin
            ratio = {16'd0, model_kernel, 16'd0} / d;
            w = (ratio * ratio) >> FRAC;
        end
        ux = px < 0 ? -px : px;
        uy = py < 0 ? -py : py;
        rad = (ux * ux + uy * uy) >>> FRAC;
        t1 = (px * ry) >>> FRAC;
        t2 = (py * rx) >>> FRAC;
        terms[ACC_WSUM] = w;
        terms[ACC_PX] = weighted(w, px);
        terms[ACC_NPY] = weighted(w, -py);
        terms[ACC_RAD] = weighted(w, rad);
        terms[ACC_GX] = weighted(w, rx);
        terms[ACC_GY] = weighted(w, ry);
        terms[ACC_ROT] = weighted(w, t1 - t2);
        for (int i = 0; i < NUM_ACC; i++)
        begin
            s = {model_acc[i][ACC_W-1], model_acc[i]} + {terms[i][ACC_W-1], terms[i]};
            if (s[ACC_W] != s[ACC_W-1])
            begin
                model_ovf = 1'b1;
                model_acc[i] = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                model_acc[i] = s[ACC_W-1:0];
            end
        end
        if (model_count < PAIR_LIMIT)
        begin
            model_count++;
        end
        if (last)
        begin
            res.sums = model_acc;
            res.count = model_count;
            res.ovf = model_ovf;
            pending_sums = {pending_sums, res};
            clear_model_sums();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h (set %0d)", what, got, want, sets_checked);
        errors++;
    endtask

    // Predict on accepted words, track kernel writes, and check each result word.
    always @(posedge clk)
    begin
        normal_eq_t want;
        logic signed [ACC_W-1:0] got[NUM_ACC];
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("weighted_icp_normal_equation_accumulator_test: done, errors");
                $finish;
            end
            if (cfg_we)
            begin
                model_kernel = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                accumulate_pair(src_x, src_y, map_x, map_y, last_pair);
            end
            if (out_valid && out_ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $display("unexpected result word (set %0d)", sets_checked);
                    errors++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    got = '{weight_sum, weighted_px_sum, weighted_neg_py_sum,
                            weighted_radius_sum, grad_x, grad_y, grad_rot};
                    for (int i = 0; i < NUM_ACC; i++)
                    begin
                        if (got[i] !== want.sums[i])
                        begin
                            report_mismatch($sformatf("sum %0d", i), got[i], want.sums[i]);
                        end
                    end
                    if (pair_count !== want.count)
                    begin
                        report_mismatch("pair_count", pair_count, want.count);
                    end
                    if (overflow_flag !== want.ovf)
                    begin
                        report_mismatch("overflow_flag", overflow_flag, want.ovf);
                    end
                end
                sets_checked++;
            end
        end
    end

    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
        end
    end

    task automatic send_pair(input logic signed [IN_W-1:0] sx, input logic signed [IN_W-1:0] sy,
                             input logic signed [IN_W-1:0] mx, input logic signed [IN_W-1:0] my,
                             input logic last);
        int n;
        n = pick_gap();
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        src_x <= sx;
        src_y <= sy;
        map_x <= mx;
        map_y <= my;
        last_pair <= last;
        in_valid <= 1'b1;
        #1;
        while (!in_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        pairs_sent++;
    endtask

    // Drain outstanding results and let any in-flight word finish.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_sums.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_kernel(input logic [KER_W-1:0] k);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= k;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        write_kernel(32'h0001_0000);
        send_pair(0, 0, 0, 0, 1'b1);
        send_pair(IN_MAX, IN_MIN, IN_MIN, IN_MAX, 1'b1);
        send_pair(IN_MIN, IN_MIN, IN_MIN, IN_MIN, 1'b0);
        send_pair(IN_MAX, IN_MAX, IN_MAX, IN_MAX, 1'b0);
        send_pair(-1, -1, 0, 0, 1'b1);
        send_pair(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 0, 1'b0);
        send_pair(-32'sh0003_0000, 32'sh0001_8000, -32'sh0003_4000, 32'sh0001_0000, 1'b1);
        send_pair(IN_MIN, IN_MAX, IN_MIN + 1, IN_MAX - 1, 1'b1);
        // zero kernel: zero residual gives a zero divisor, others give zero weight
        write_kernel(32'h0000_0000);
        send_pair(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b0);
        send_pair(32'sh0001_0000, 0, 0, 0, 1'b1);
        write_kernel(32'hFFFF_FFFF);
        send_pair(IN_MAX, IN_MIN, IN_MAX - 32'sh0100_0000, IN_MIN, 1'b0);
        send_pair(32'sh1234_5678, -32'sh0765_4321, 32'sh1200_0000, -32'sh0700_0000, 1'b1);
        send_pair(IN_MIN, IN_MIN, IN_MAX, IN_MAX, 1'b1);
        write_kernel(32'h0000_0001);
        send_pair(0, 0, 0, 0, 1'b0);
        send_pair(1, -1, 0, 0, 1'b1);
    endtask

    function automatic logic signed [IN_W-1:0] random_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $urandom_range(0, 1) ? IN_MAX : IN_MIN;
            default: return $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
        endcase
    endfunction

    function automatic logic signed [IN_W-1:0] random_offset();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 0;
            default: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
        endcase
    endfunction

    task automatic test_random_sets(input int total);
        int sent;
        int len;
        logic signed [IN_W-1:0] sx, sy;
        logic [KER_W-1:0] kernels[5];
        kernels = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0010_0000};
        sent = 0;
        while (sent < total)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_kernel($urandom_range(0, 1) ? kernels[$urandom_range(0, 4)] : $urandom);
            end
            // hold gaps off for some sets so back-to-back traffic is covered too
            no_gaps = $urandom_range(0, 4) == 0;
            len = $urandom_range(0, 5) == 0 ? $urandom_range(9, 30) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                sx = random_coord();
                sy = random_coord();
                send_pair(sx, sy, sx - random_offset(), sy - random_offset(), i == len - 1);
            end
            sent += len;
        end
        no_gaps = 1'b0;
    endtask

    // One long set of corner points, sent back to back, to build large sums.
    task automatic test_long_set();
        logic signed [IN_W-1:0] sx, sy;
        write_kernel(32'h0001_0000);
        no_gaps = 1'b1;
        for (int i = 0; i < LONG_SET; i++)
        begin
            sx = $urandom_range(0, 1) ? IN_MAX : IN_MIN;
            sy = $urandom_range(0, 1) ? IN_MAX : IN_MIN;
            send_pair(sx, sy, sx - random_offset(), sy - random_offset(), i == LONG_SET - 1);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        pairs_sent = 0;
        sets_checked = 0;
        cycles = 0;
        no_gaps = 1'b0;
        model_kernel = 32'h0001_0000;
        clear_model_sums();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        src_x = '0;
        src_y = '0;
        map_x = '0;
        map_y = '0;
        last_pair = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_extremes();
        test_random_sets(400);
        test_long_set();
        write_kernel(32'h0001_0000);
        test_random_sets(20);
        wait_idle();
        $display("covered %0d point pairs in %0d sets: directed extremes, zero kernel,",
                 pairs_sent, sets_checked);
        $display("random kernels and sets, one long back-to-back set of corner points");
        if (errors == 0)
        begin
            $display("weighted_icp_normal_equation_accumulator_test: done, clean");
        end
        else
        begin
            $display("weighted_icp_normal_equation_accumulator_test: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wicp_pkg.sv
rtl/wicp_div.sv
rtl/wicp_dp.sv
rtl/wicp_ctrl.sv
rtl/weighted_icp_normal_equation_accumulator.sv
bench/weighted_icp_normal_equation_accumulator_test.sv
